// ----- hw/rtl/rc_decay_line_sensor_reader_unit_assert.svh -----
// Assertion macros shared by the RC decay sensor reader RTL.
`ifndef RC_DECAY_LINE_SENSOR_READER_UNIT_ASSERT_SVH
`define RC_DECAY_LINE_SENSOR_READER_UNIT_ASSERT_SVH

// Condition holds at every clock edge out of reset.
`define RCD_ASSERT_HOLDS(lbl, cond, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) else $error(msg);

// Same-cycle implication.
`define RCD_ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define RCD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/rcd_pkg.sv -----
// Shared types and constants of the RC decay sensor reader.
`default_nettype none

package rcd_pkg;

    localparam int NUM_SENSORS   = 5;
    localparam int TIMEOUT_TICKS = 1024;

    localparam int LEVEL_W    = 11;    // output level field width
    localparam int MIN_SPAN_W = 11;
    localparam int FULL_SCALE = 1000;
    localparam int QUOT_W     = 10;    // scaled value is always below 1024

    localparam int PIN_W       = 5;
    localparam int S_TDATA_W   = ((PIN_W + 7) / 8) * 8;
    localparam int REQ_W       = 2;
    localparam int M_PAYLOAD_W = NUM_SENSORS * LEVEL_W + 1;
    localparam int M_TDATA_W   = ((M_PAYLOAD_W + 7) / 8) * 8;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;

    // request kinds carried in s_tuser
    localparam logic [REQ_W-1:0] REQ_SAMPLE = 2'd0;
    localparam logic [REQ_W-1:0] REQ_START  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CAL_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_SPAN = 2'd1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CLOSE,
        ST_WAIT
    } rcd_state_t;

    // control broadcast from the sequencer to every lane
    typedef struct packed {
        logic start;
        logic sample;
        logic clear;
        logic close;
        logic cal_mode;
    } rcd_lane_ctrl_t;

endpackage

`default_nettype wire

// ----- hw/rtl/rcd_div.sv -----
// Restoring divider, one quotient bit per cycle, for the lane scaling step.
`default_nettype none

module rcd_div #(
    parameter int TW = 11
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           start,
    input  wire logic [TW+rcd_pkg::QUOT_W-1:0]  num,
    input  wire logic [TW-1:0]                  den,
    output logic                                done,
    output logic [rcd_pkg::QUOT_W-1:0]          quot
);

    localparam int QW  = rcd_pkg::QUOT_W;
    localparam int NW  = TW + QW;
    localparam int DSW = TW + QW - 1;
    localparam int CW  = $clog2(QW + 1);

    logic [NW-1:0]  rem_reg,  rem_next;
    logic [DSW-1:0] dsh_reg,  dsh_next;
    logic [QW-1:0]  quot_reg, quot_next;
    logic [CW-1:0]  step_reg, step_next;
    logic           done_reg, done_next;
    logic           ge;

    // quotient fits QW bits, so the divisor starts shifted up by QW-1
    always_comb begin
        ge        = rem_reg >= NW'(dsh_reg);
        rem_next  = rem_reg;
        dsh_next  = dsh_reg;
        quot_next = quot_reg;
        step_next = step_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next  = num;
            dsh_next  = {den, {(QW-1){1'b0}}};
            step_next = CW'(QW);
        end else if (step_reg != '0) begin
            if (ge) begin
                rem_next = rem_reg - NW'(dsh_reg);
            end
            quot_next = {quot_reg[QW-2:0], ge};
            dsh_next  = dsh_reg >> 1;
            step_next = step_reg - 1'b1;
            done_next = step_reg == CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg  <= rem_next;
        dsh_reg  <= dsh_next;
        quot_reg <= quot_next;
        if (!aresetn) begin
            step_reg <= '0;
            done_reg <= 1'b0;
        end else begin
            step_reg <= step_next;
            done_reg <= done_next;
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/rcd_lane.sv -----
// One sensor lane: decay timer, min/max calibration and scaling.
`default_nettype none

module rcd_lane #(
    parameter int TIMEOUT_TICKS = rcd_pkg::TIMEOUT_TICKS
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire rcd_pkg::rcd_lane_ctrl_t         ctrl,
    input  wire logic [$clog2(TIMEOUT_TICKS+2)-1:0] tick,
    input  wire logic                            pin,
    input  wire logic [rcd_pkg::MIN_SPAN_W-1:0]  min_span,
    output logic                                 pend_after,
    output logic [rcd_pkg::LEVEL_W-1:0]          level,
    output logic                                 ready,
    output logic                                 span_ok
);

    localparam int TW = $clog2(TIMEOUT_TICKS + 2);
    localparam int QW = rcd_pkg::QUOT_W;
    localparam int NW = TW + QW;
    localparam int LW = rcd_pkg::LEVEL_W;
    localparam int SW = ((TW > rcd_pkg::MIN_SPAN_W) ? TW : rcd_pkg::MIN_SPAN_W) + 1;
    localparam int FULL_SCALE_C = rcd_pkg::FULL_SCALE;

    logic          pend_reg,  pend_next;
    logic [TW-1:0] decay_reg, decay_next;
    logic [TW-1:0] lo_reg,    lo_next;
    logic [TW-1:0] hi_reg,    hi_next;
    logic [LW-1:0] level_reg, level_next;
    logic          ready_reg, ready_next;
    logic          pend_cur;
    logic          div_start;
    logic [NW-1:0] div_num;
    logic [TW-1:0] div_den;
    logic          div_done;
    logic [QW-1:0] div_quot;

    assign pend_cur   = ctrl.start | pend_reg;
    assign pend_after = pend_cur & pin;

    always_comb begin
        pend_next  = pend_reg;
        decay_next = decay_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        level_next = level_reg;
        ready_next = ready_reg;
        div_start  = 1'b0;
        div_num    = NW'(decay_reg - lo_reg) * NW'(FULL_SCALE_C);
        div_den    = hi_reg - lo_reg;

        if (ctrl.start) begin
            decay_next = TW'(TIMEOUT_TICKS);
        end
        if (ctrl.sample) begin
            if (pend_cur && !pin) begin
                decay_next = tick;
            end
            pend_next = pend_after;
        end
        if (ctrl.clear) begin
            lo_next = TW'(TIMEOUT_TICKS + 1);
            hi_next = '0;
        end

        if (ctrl.close) begin
            pend_next  = 1'b0;
            ready_next = 1'b1;
            if (ctrl.cal_mode) begin
                if (decay_reg < lo_reg) lo_next = decay_reg;
                if (decay_reg > hi_reg) hi_next = decay_reg;
                level_next = LW'(decay_reg);
            end else if (hi_reg <= lo_reg || decay_reg <= lo_reg) begin
                level_next = '0;
            end else if (decay_reg >= hi_reg) begin
                level_next = LW'(FULL_SCALE_C);
            end else begin
                div_start  = 1'b1;
                ready_next = 1'b0;
            end
        end else if (div_done) begin
            level_next = LW'(div_quot);
            ready_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        decay_reg <= decay_next;
        level_reg <= level_next;
        if (!aresetn) begin
            pend_reg  <= 1'b0;
            lo_reg    <= TW'(TIMEOUT_TICKS + 1);
            hi_reg    <= '0;
            ready_reg <= 1'b0;
        end else begin
            pend_reg  <= pend_next;
            lo_reg    <= lo_next;
            hi_reg    <= hi_next;
            ready_reg <= ready_next;
        end
    end

    rcd_div #(
        .TW(TW)
    ) u_div (
        .aclk   (aclk),
        .aresetn(aresetn),
        .start  (div_start),
        .num    (div_num),
        .den    (div_den),
        .done   (div_done),
        .quot   (div_quot)
    );

    assign span_ok = SW'(hi_reg) >= (SW'(lo_reg) + SW'(min_span));
    assign level   = level_reg;
    assign ready   = ready_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/rcd_merge.sv -----
// Merges lane results and the calibration flag into the output register.
`default_nettype none

module rcd_merge (
    input  wire logic                                                 aclk,
    input  wire logic                                                 aresetn,
    input  wire logic                                                 load,
    input  wire logic [rcd_pkg::NUM_SENSORS-1:0][rcd_pkg::LEVEL_W-1:0] levels,
    input  wire logic [rcd_pkg::NUM_SENSORS-1:0]                      span_ok,
    output logic                                                      out_free,
    output logic                                                      m_tvalid,
    input  wire logic                                                 m_tready,
    output logic [rcd_pkg::M_TDATA_W-1:0]                             m_tdata
);

    logic                          tvalid_reg, tvalid_next;
    logic [rcd_pkg::M_TDATA_W-1:0] tdata_reg,  tdata_next;

    assign out_free = !tvalid_reg || m_tready;

    always_comb begin
        tvalid_next = tvalid_reg;
        tdata_next  = tdata_reg;
        if (m_tready) begin
            tvalid_next = 1'b0;
        end
        if (load) begin
            tvalid_next = 1'b1;
            tdata_next  = rcd_pkg::M_TDATA_W'({&span_ok, levels});
        end
    end

    always_ff @(posedge aclk) begin
        tdata_reg <= tdata_next;
        if (!aresetn) begin
            tvalid_reg <= 1'b0;
        end else begin
            tvalid_reg <= tvalid_next;
        end
    end

    assign m_tvalid = tvalid_reg;
    assign m_tdata  = tdata_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/rc_decay_line_sensor_reader_unit.sv -----
// Top level of the RC decay line sensor reader: sequencer, five lanes, merge.
//
// Input channel (s_*): one word per timer tick. s_tuser carries the request kind
// (sample, start, clear calibration), s_tdata the five pin levels; pin bit b
// belongs to sensor 4-b. While a measurement runs the block takes one word every
// cycle. A word that closes the measurement (all pins fallen, or the timeout
// tick reached) stops input for the closing phase.
// Closing: the lanes update calibration or scale their times; scaling runs a
// per-lane bit-serial divider, one quotient bit per cycle. The result word is
// loaded into the output register after the sequencer passes the close and
// wait states; in read mode the wait state also lasts until each divider is done.
// Output channel (m_*): one word per measurement, held in a register until
// taken; a stalled receiver only delays input once a next result is ready to
// load. Config channel (cfg_*): index 0 calibrate mode, index 1 min span; it is
// always ready; it must be written while the block is idle, which the block does not enforce.
// Reset: synchronous, active low; no measurement running, calibration cleared,
// calibrate mode off, min span 100.
`default_nettype none

module rc_decay_line_sensor_reader_unit #(
    parameter int TIMEOUT_TICKS = rcd_pkg::TIMEOUT_TICKS
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    // input words
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [rcd_pkg::S_TDATA_W-1:0]    s_tdata,   // [4:0] pin_levels
    input  wire logic [rcd_pkg::REQ_W-1:0]        s_tuser,   // [1:0] req_type
    // result words
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // [10:0] level_0, [21:11] level_1, [32:22] level_2, [43:33] level_3,
    // [54:44] level_4, [55] calibration_ok
    output logic [rcd_pkg::M_TDATA_W-1:0]         m_tdata,
    // configuration writes
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [rcd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [rcd_pkg::CFG_DATA_W-1:0]   cfg_data
);

`include "rc_decay_line_sensor_reader_unit_assert.svh"

    localparam int TW = $clog2(TIMEOUT_TICKS + 2);
    localparam int NS = rcd_pkg::NUM_SENSORS;
    localparam int LW = rcd_pkg::LEVEL_W;

    rcd_pkg::rcd_state_t state_reg, state_next;

    logic                           measuring_reg, measuring_next;
    logic [TW-1:0]                  tick_reg,      tick_next;
    logic                           cal_mode_reg,  cal_mode_next;
    logic [rcd_pkg::MIN_SPAN_W-1:0] min_span_reg,  min_span_next;

    logic                  acc;
    logic                  is_start, is_samp, is_clear;
    logic [TW-1:0]         tick_val;
    logic                  timeout;
    logic                  close_now;
    logic                  load;
    logic                  out_free;
    rcd_pkg::rcd_lane_ctrl_t ctrl;

    logic [NS-1:0]         lane_pend;
    logic [NS-1:0]         lane_ready;
    logic [NS-1:0]         lane_span_ok;
    logic [NS-1:0][LW-1:0] lane_level;

    // ---- input decode ----
    assign s_tready = state_reg == rcd_pkg::ST_IDLE;
    assign acc      = s_tvalid && s_tready;
    assign is_start = acc && s_tuser == rcd_pkg::REQ_START;
    assign is_samp  = acc && s_tuser == rcd_pkg::REQ_SAMPLE && measuring_reg;
    assign is_clear = acc && s_tuser == rcd_pkg::REQ_CLEAR;

    // tick of the current word; a start samples at tick zero
    assign tick_val = is_start ? '0 : tick_reg + 1'b1;
    // the timeout tick closes without looking at the pins
    assign timeout  = is_samp && tick_val >= TW'(TIMEOUT_TICKS);

    always_comb begin
        ctrl.start    = is_start;
        ctrl.sample   = (is_start || is_samp) && !timeout;
        ctrl.clear    = is_clear;
        ctrl.close    = state_reg == rcd_pkg::ST_CLOSE;
        ctrl.cal_mode = cal_mode_reg;
    end

    assign close_now = timeout || (ctrl.sample && lane_pend == '0);
    assign load      = state_reg == rcd_pkg::ST_WAIT && (&lane_ready) && out_free;

    // ---- sequencer ----
    always_comb begin
        state_next     = state_reg;
        measuring_next = measuring_reg;
        tick_next      = tick_reg;
        unique case (state_reg)
            rcd_pkg::ST_IDLE: begin
                if (is_start || is_samp) begin
                    tick_next = tick_val;
                end
                if (is_start) begin
                    measuring_next = 1'b1;
                end
                if (close_now) begin
                    measuring_next = 1'b0;
                    state_next     = rcd_pkg::ST_CLOSE;
                end
            end
            rcd_pkg::ST_CLOSE: begin
                state_next = rcd_pkg::ST_WAIT;
            end
            rcd_pkg::ST_WAIT: begin
                if (load) begin
                    state_next = rcd_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = rcd_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= rcd_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            measuring_reg <= 1'b0;
            tick_reg      <= '0;
        end else begin
            measuring_reg <= measuring_next;
            tick_reg      <= tick_next;
        end
    end

    // ---- configuration registers ----
    assign cfg_ready = 1'b1;

    always_comb begin
        cal_mode_next = cal_mode_reg;
        min_span_next = min_span_reg;
        if (cfg_valid && cfg_ready) begin
            priority if (cfg_index == rcd_pkg::CFG_CAL_MODE) begin
                cal_mode_next = cfg_data[0];
            end else if (cfg_index == rcd_pkg::CFG_MIN_SPAN) begin
                min_span_next = cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cal_mode_reg <= 1'b0;
            min_span_reg <= rcd_pkg::MIN_SPAN_W'(100);
        end else begin
            cal_mode_reg <= cal_mode_next;
            min_span_reg <= min_span_next;
        end
    end

    // ---- lanes: sensor i sees pin bit NS-1-i ----
    for (genvar i = 0; i < NS; i++) begin : g_lane
        rcd_lane #(
            .TIMEOUT_TICKS(TIMEOUT_TICKS)
        ) u_lane (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .ctrl      (ctrl),
            .tick      (tick_val),
            .pin       (s_tdata[NS-1-i]),
            .min_span  (min_span_reg),
            .pend_after(lane_pend[i]),
            .level     (lane_level[i]),
            .ready     (lane_ready[i]),
            .span_ok   (lane_span_ok[i])
        );
    end

    // ---- merge and output register ----
    rcd_merge u_merge (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load    (load),
        .levels  (lane_level),
        .span_ok (lane_span_ok),
        .out_free(out_free),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    // ---- checks ----
    `RCD_ASSERT_IMPLIES(a_tick_bound, measuring_reg, tick_reg < TW'(TIMEOUT_TICKS), "tick past timeout while measuring")
    `RCD_ASSERT_NEXT(a_close_stops, close_now && state_reg == rcd_pkg::ST_IDLE, !measuring_reg && state_reg == rcd_pkg::ST_CLOSE, "close did not end the measurement")
    `RCD_ASSERT_NEXT(a_cal_no_div, state_reg == rcd_pkg::ST_CLOSE && cal_mode_reg, &lane_ready, "calibrate close left a lane busy")

endmodule

`default_nettype wire

// ----- bench/tb_rc_decay_line_sensor_reader_unit.sv -----
`timescale 1ns / 1ps
// Self-checking bench for the RC decay line sensor reader: random timing, predicted readings.
module tb_rc_decay_line_sensor_reader_unit;
    import rcd_pkg::*;

    // request code the block must ignore
    localparam logic [REQ_W-1:0]     REQ_UNUSED  = 2'd3;
    // register indexes past the end of the map, writes are dropped
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

    localparam int IDLE_LIMIT     = 4000;  // cycles with no handshake at all
    localparam int DRAIN_CYCLES   = 20;    // quiet time after the last reading
    localparam int PHASE_WORDS    = 150;
    localparam int NUM_PHASES     = 6;

    logic                  aclk;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;   // [4:0] pin_levels
    logic [REQ_W-1:0]      s_tuser   = '0;   // [1:0] req_type
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    // [10:0] level_0 ... [54:44] level_4, [55] calibration_ok
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    int idle_cycles = 0;
    int meas_words  = 0;
    bit send_steady = 1'b0;
    bit recv_steady = 1'b0;

    typedef struct packed {
        logic [NUM_SENSORS-1:0][LEVEL_W-1:0] level;
        logic                                ok;
    } reading_t;

    // Tracks the sensor timer and calibration, and holds the readings still due.
    class decay_scoreboard;
        bit                    cal_mode;
        logic [MIN_SPAN_W-1:0] min_span;
        int                    tick;
        logic [NUM_SENSORS-1:0] pending;
        bit                    measuring;
        int                    decay[NUM_SENSORS];
        int                    cal_lo[NUM_SENSORS];
        int                    cal_hi[NUM_SENSORS];
        reading_t              expected_q[$];
        int                    errors;

        function new();
            cal_mode  = 1'b0;
            min_span  = MIN_SPAN_W'(100);
            tick      = 0;
            pending   = '0;
            measuring = 1'b0;
            errors    = 0;
            foreach (decay[i]) decay[i] = 0;
            clear_cal();
        endfunction

        function void clear_cal();
            foreach (cal_lo[i]) begin
                cal_lo[i] = TIMEOUT_TICKS + 1;
                cal_hi[i] = 0;
            end
        endfunction

        function void note_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == CFG_CAL_MODE) begin
                cal_mode = data[0];
            end else if (idx == CFG_MIN_SPAN) begin
                min_span = data;
            end
        endfunction

        // Measurement closes: fold times into calibration, then scale or pass raw.
        function void close_reading();
            reading_t r;
            int raw, lo, hi, val;
            measuring = 1'b0;
            pending   = '0;
            r.ok      = 1'b1;
            for (int i = 0; i < NUM_SENSORS; i++) begin
                raw = decay[i];
                if (cal_mode) begin
                    if (raw < cal_lo[i]) cal_lo[i] = raw;
                    if (raw > cal_hi[i]) cal_hi[i] = raw;
                end
                lo = cal_lo[i];
                hi = cal_hi[i];
                if (cal_mode)
                    val = raw;
                else if (hi <= lo || raw <= lo)
                    val = 0;              // empty range, or at/below the low mark
                else if (raw >= hi)
                    val = FULL_SCALE;
                else
                    val = (raw - lo) * FULL_SCALE / (hi - lo);
                r.level[i] = val[LEVEL_W-1:0];
            end
            for (int i = 0; i < NUM_SENSORS; i++) begin
                if (cal_hi[i] < cal_lo[i] + int'(min_span)) r.ok = 1'b0;
            end
            expected_q.push_back(r);
        endfunction

        function void note_word(logic [REQ_W-1:0] req, logic [PIN_W-1:0] pins);
            logic [NUM_SENSORS-1:0] fell;
            case (req)
                REQ_CLEAR: begin
                    clear_cal();      // running measurement keeps going
                    return;
                end
                REQ_START: begin
                    measuring = 1'b1;
                    tick      = 0;
                    pending   = '1;
                    foreach (decay[i]) decay[i] = TIMEOUT_TICKS;
                end
                REQ_SAMPLE: begin
                    if (!measuring) return;
                    tick++;
                end
                default: return;
            endcase
            // timeout tick closes without looking at the pins
            if (tick >= TIMEOUT_TICKS) begin
                close_reading();
                return;
            end
            // pin bit b belongs to sensor NUM_SENSORS-1-b
            fell = pending & ~pins;
            for (int b = 0; b < NUM_SENSORS; b++) begin
                if (fell[b]) decay[NUM_SENSORS-1-b] = tick;
            end
            pending &= pins;
            if (pending == '0) close_reading();
        endfunction

        function void check_reading(logic [M_TDATA_W-1:0] word);
            reading_t want;
            if (expected_q.size() == 0) begin
                $error("unexpected result word %h", word);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            for (int i = 0; i < NUM_SENSORS; i++) begin
                if (word[i*LEVEL_W +: LEVEL_W] !== want.level[i]) begin
                    $error("level_%0d expected %0d actual %0d", i, want.level[i],
                           word[i*LEVEL_W +: LEVEL_W]);
                    errors++;
                end
            end
            if (word[NUM_SENSORS*LEVEL_W] !== want.ok) begin
                $error("calibration_ok expected %0d actual %0d", want.ok,
                       word[NUM_SENSORS*LEVEL_W]);
                errors++;
            end
        endfunction
    endclass

    decay_scoreboard sb = new();

    rc_decay_line_sensor_reader_unit DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Handshake monitor: feeds the scoreboard and the no-progress counter.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) sb.note_word(s_tuser, s_tdata[PIN_W-1:0]);
            if (m_tvalid && m_tready) sb.check_reading(m_tdata);
            if (cfg_valid && cfg_ready) sb.note_reg(cfg_index, cfg_data);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        wait (idle_cycles >= IDLE_LIMIT);
        $display("tb: failure");
        $finish;
    end

    // Receiver: random stall before each word, with stall-free stretches.
    initial begin
        int stall;
        @(posedge aclk);
        forever begin
            if ($urandom_range(0, 47) == 0) recv_steady = !recv_steady;
            stall = recv_steady ? 0 : $urandom_range(0, 16);
            if (stall != 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    task automatic send_word(input logic [REQ_W-1:0] req, input logic [PIN_W-1:0] pins);
        int gap;
        if ($urandom_range(0, 63) == 0) send_steady = !send_steady;
        gap = send_steady ? 0 : $urandom_range(0, 16);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= {{(S_TDATA_W-PIN_W){1'b0}}, pins};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // Hold input off until every reading is back and the closing path is quiet.
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.expected_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // One measurement: start word at tick zero, then one sample per tick until
    // every pin has fallen or the timeout tick. Sometimes cut short, so the
    // next start lands on a running measurement.
    task automatic run_measurement(input bit to_timeout);
        int fall[NUM_SENSORS];
        int last;
        int abort_at;
        bit wide;
        logic [PIN_W-1:0] pins;
        wide = ($urandom_range(0, 4) == 0);
        last = 0;
        foreach (fall[i]) fall[i] = wide ? $urandom_range(0, 250) : $urandom_range(0, 10);
        if (to_timeout) fall[$urandom_range(0, NUM_SENSORS-1)] = TIMEOUT_TICKS + 1;
        foreach (fall[i]) if (fall[i] > last) last = fall[i];
        if (last > TIMEOUT_TICKS) last = TIMEOUT_TICKS;
        abort_at = ($urandom_range(0, 15) == 0) ? $urandom_range(1, last) : -1;
        for (int t = 0; t <= last; t++) begin
            if (t == abort_at && t > 0) return;
            // high until the fall tick, low at it, noise afterwards
            foreach (fall[s])
                pins[NUM_SENSORS-1-s] = (t < fall[s]) ? 1'b1 :
                                        (t == fall[s]) ? 1'b0 : 1'($urandom_range(0, 1));
            if (t == TIMEOUT_TICKS) pins = PIN_W'($urandom);
            send_word(t == 0 ? REQ_START : REQ_SAMPLE, pins);
            meas_words++;
            if (t != 0 && t != last && $urandom_range(0, 59) == 0)
                send_word(REQ_CLEAR, PIN_W'($urandom));
            if ($urandom_range(0, 59) == 0) send_word(REQ_UNUSED, PIN_W'($urandom));
        end
    endtask

    initial begin
        bit cal_plan[NUM_PHASES];
        int span_plan[NUM_PHASES];
        bit timeout_plan[NUM_PHASES];
        int words_at, span;

        cal_plan     = '{1, 0, 1, 0, 0, 1};
        span_plan    = '{100, 0, 1024, 1024, -1, -1};  // -1: random
        timeout_plan = '{0, 0, 1, 0, 0, 0};

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // --- directed: reset calibration is empty, read mode gives zeros
        send_word(REQ_SAMPLE, 5'b11111);      // sample while idle
        send_word(REQ_UNUSED, 5'b00000);
        send_word(REQ_START,  5'b11111);
        send_word(REQ_SAMPLE, 5'b10111);
        send_word(REQ_SAMPLE, 5'b00000);
        send_word(REQ_START,  5'b00000);      // everything low at tick zero
        send_word(REQ_START,  5'b11111);
        send_word(REQ_CLEAR,  5'b11111);      // clear mid-measurement
        send_word(REQ_SAMPLE, 5'b00000);
        send_word(REQ_START,  5'b11111);
        send_word(REQ_SAMPLE, 5'b11111);
        send_word(REQ_START,  5'b11111);      // restart while measuring
        send_word(REQ_SAMPLE, 5'b01010);
        send_word(REQ_SAMPLE, 5'b00000);
        settle();

        // calibrate: sensor 4 low at tick zero, then a slower pass
        write_reg(CFG_CAL_MODE, 11'd1);
        send_word(REQ_START,  5'b11110);
        send_word(REQ_SAMPLE, 5'b00000);
        send_word(REQ_START,  5'b11111);
        send_word(REQ_SAMPLE, 5'b11111);
        send_word(REQ_SAMPLE, 5'b11111);
        send_word(REQ_SAMPLE, 5'b00000);
        settle();

        // read: mid-range scaling, clamp low, clamp high
        write_reg(CFG_CAL_MODE, 11'd0);
        send_word(REQ_START,  5'b11111);
        send_word(REQ_SAMPLE, 5'b11111);
        send_word(REQ_SAMPLE, 5'b00000);
        send_word(REQ_START,  5'b00000);
        send_word(REQ_START,  5'b11111);
        repeat (4) send_word(REQ_SAMPLE, 5'b11111);
        send_word(REQ_SAMPLE, 5'b00000);
        settle();

        // --- random phases, each with its own register setting
        for (int p = 0; p < NUM_PHASES; p++) begin
            span = (span_plan[p] < 0) ? $urandom_range(0, 1024) : span_plan[p];
            write_reg(CFG_CAL_MODE, CFG_DATA_W'(cal_plan[p]));
            write_reg(CFG_MIN_SPAN, CFG_DATA_W'(span));
            if (p == 0) begin
                write_reg(CFG_SPARE_2, CFG_DATA_W'($urandom));
                write_reg(CFG_SPARE_3, CFG_DATA_W'($urandom));
            end
            words_at = meas_words;
            if (timeout_plan[p]) run_measurement(1'b1);
            while (meas_words - words_at < PHASE_WORDS) begin
                if ($urandom_range(0, 4) == 0) send_word(REQ_SAMPLE, PIN_W'($urandom));
                if ($urandom_range(0, 39) == 0) send_word(REQ_CLEAR, PIN_W'($urandom));
                run_measurement(1'b0);
            end
            // a start with all pins low always closes at once
            send_word(REQ_START, '0);
            settle();
        end

        if (sb.errors == 0 && sb.expected_q.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
